@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the core RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define BSDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define BSDE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/core/bsde_pkg.sv @@
// Package with types and constants for the sparse bitmask dequant expander
`timescale 1ns / 1ps

package bsde_pkg;

  // Field widths
  localparam int CODE_BITS    = 16;
  localparam int WORD_BITS    = 32;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 5;
  localparam int NPOS_W       = 6;
  localparam int WORD_LIMIT   = (WORD_BITS < 32) ? WORD_BITS : 32;

  // Code buffer
  localparam int DEPTH        = 64;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_VALUE = 4'd0,
    CFG_MAX_VALUE = 4'd1
  } cfg_reg_e;

  localparam logic signed [VAL_W-1:0] MIN_RESET = 32'sd0;
  localparam logic signed [VAL_W-1:0] MAX_RESET = 32'sd65536;

  // Dequant arithmetic widths
  localparam int DEN_W  = VAL_W + 1;             // max - min
  localparam int PROD_W = CODE_BITS + 1 + DEN_W; // code * span
  localparam int SUM_W  = PROD_W + 1;            // plus min * (2^m - 1)
  localparam int MAG_W  = SUM_W - 1;
  localparam int H_W    = MAG_W - CODE_BITS;
  localparam int S1_W   = H_W + 1;
  localparam int QA_W   = H_W + 1;
  localparam int H2_W   = S1_W - CODE_BITS;
  localparam int S2_W   = H2_W + 1;
  localparam int H3_W   = S2_W - CODE_BITS;
  localparam int S3_W   = CODE_BITS + 1;

  localparam logic [CODE_BITS:0] CODE_SPAN = {1'b0, {CODE_BITS{1'b1}}};

  // Zero code
  localparam int ZC_W = CODE_BITS + 2;
  localparam logic signed [ZC_W-1:0] ZC_LO    = -$signed(ZC_W'(2));
  localparam logic signed [ZC_W-1:0] ZC_HI    = ZC_W'(1) << CODE_BITS;
  localparam logic signed [ZC_W-1:0] ZC_RESET = '0;

  typedef enum logic {
    REQ_CODE  = 1'b0,
    REQ_FLAGS = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e                req_type;
    logic [CODE_BITS-1:0]     code;
    logic [WORD_BITS-1:0]     flag_word;
    logic [NPOS_W-1:0]        valid_positions;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  out_value;
    logic [POS_W-1:0]         position;
    logic                     last_of_word;
    logic                     underflow;
    logic                     overflow_seen;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic              push;
    logic              load_word;
    logic              issue;
    logic              last;
    logic [POS_W-1:0]  pos;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic zc_busy;
    logic adv;
  } dp_status_t;

endpackage

@@ rtl/core/bsde_zc_div.sv @@
// Iterative unit that derives the zero code from min and max
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsde_zc_div import bsde_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [VAL_W-1:0] min_i,
  input  logic signed [VAL_W-1:0] max_i,
  output logic                    busy_o,
  output logic signed [ZC_W-1:0]  zc_o
);

  localparam int P_W    = DEN_W + CODE_BITS;
  localparam int DVD_W  = P_W - 1;
  localparam int REM_W  = VAL_W + 1;
  localparam int ITER_W = $clog2(DVD_W);
  localparam int RES_W  = DVD_W + 2;

  typedef enum logic [4:0] {
    DV_IDLE = 5'b00001,
    DV_LOAD = 5'b00010,
    DV_PREP = 5'b00100,
    DV_ITER = 5'b01000,
    DV_FIN  = 5'b10000
  } div_state_e;

  div_state_e state_q, state_d;

  logic signed [DEN_W-1:0] den_w;
  logic signed [DEN_W-1:0] num_q;
  logic [VAL_W-1:0]        den_abs_q;
  logic                    den_zero_q;
  logic signed [P_W-1:0]   p_w;
  logic [P_W-1:0]          pabs_w;
  logic                    pneg_q;
  logic                    ceil_q;
  logic [DVD_W-1:0]        dvd_q;
  logic [REM_W-1:0]        rem_q;
  logic [REM_W-1:0]        rem_sh;
  logic                    ge;
  logic [ITER_W-1:0]       cnt_q;
  logic signed [RES_W-1:0] qs;
  logic signed [RES_W-1:0] res;
  logic                    rz;
  logic signed [ZC_W-1:0]  zc_q;

  assign den_w  = DEN_W'(max_i) - DEN_W'(min_i);
  assign p_w    = $signed({num_q, {CODE_BITS{1'b0}}}) - P_W'(num_q);
  assign pabs_w = p_w[P_W-1] ? P_W'(-p_w) : P_W'(p_w);
  assign rem_sh = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, den_abs_q};

  // Round the quotient by the sign of the product and the ceil/floor choice
  always_comb begin
    qs = RES_W'(dvd_q);
    rz = rem_q != '0;
    if (ceil_q) begin
      res = pneg_q ? -qs : qs + RES_W'(rz);
    end else begin
      res = pneg_q ? -qs - RES_W'(rz) : qs;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE: if (start_i) state_d = DV_LOAD;
      DV_LOAD: state_d = DV_PREP;
      DV_PREP: state_d = den_zero_q ? DV_FIN : DV_ITER;
      DV_ITER: if (cnt_q == ITER_W'(DVD_W - 1)) state_d = DV_FIN;
      DV_FIN:  state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      zc_q    <= ZC_RESET;
    end else begin
      state_q <= state_d;
      if (state_q == DV_FIN) begin
        if (den_zero_q) begin
          zc_q <= ZC_LO;
        end else if (res < RES_W'(ZC_LO)) begin
          zc_q <= ZC_LO;
        end else if (res > RES_W'(ZC_HI)) begin
          zc_q <= ZC_HI;
        end else begin
          zc_q <= res[ZC_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_LOAD: begin
        // Fold a negative span into the numerator sign
        den_abs_q  <= den_w[DEN_W-1] ? VAL_W'(-den_w) : VAL_W'(den_w);
        num_q      <= den_w[DEN_W-1] ? DEN_W'(min_i) : -DEN_W'(min_i);
        den_zero_q <= den_w == '0;
      end
      DV_PREP: begin
        pneg_q <= p_w[P_W-1];
        ceil_q <= $signed({num_q, 1'b0}) > $signed({2'b00, den_abs_q});
        dvd_q  <= pabs_w[DVD_W-1:0];
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      DV_ITER: begin
        rem_q <= ge ? rem_sh - {1'b0, den_abs_q} : rem_sh;
        dvd_q <= {dvd_q[DVD_W-2:0], ge};
        cnt_q <= cnt_q + ITER_W'(1);
      end
      default: ;
    endcase
  end

  assign busy_o = state_q != DV_IDLE;
  assign zc_o   = zc_q;

  `BSDE_ASSERT(a_rem_below_divisor, (state_q == DV_ITER) |-> (rem_q < {1'b0, den_abs_q}), "zero code divider remainder out of range")

endmodule

@@ rtl/core/bsde_datapath.sv @@
// Datapath: configuration, code buffer, and dequantization pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsde_datapath import bsde_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  input  logic [CODE_BITS-1:0] code_i,
  input  logic [WORD_BITS-1:0] flag_word_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VAL_W-1:0]     cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  typedef struct packed {
    logic             valid;
    logic             use_code;
    logic             zero;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             under;
    logic             ovf;
  } elem_meta_t;

  // Configuration
  logic signed [VAL_W-1:0] min_q;
  logic signed [VAL_W-1:0] max_q;
  logic signed [DEN_W-1:0] den_q;
  logic signed [ZC_W-1:0]  zc;
  logic                    zc_busy;
  logic                    cfg_wr;
  logic                    cfg_hit;

  // Code buffer
  logic [CODE_BITS-1:0] code_mem_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     held_q;
  logic                 full;
  logic                 push_ok;
  logic                 bit_set;
  logic                 pop;
  logic                 ovf_sticky_q;
  logic                 ovf_word_q;
  logic [WORD_BITS-1:0] flag_q;

  // Pipeline
  logic                    adv;
  elem_meta_t              m1_d, m1_q, m2_d, m2_q, m3_q, m4_q, m5_q;
  logic [CODE_BITS-1:0]    rd_code_q;
  logic signed [ZC_W-1:0]  code_ext;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0] min_scaled;
  logic signed [SUM_W-1:0] x_q;
  logic [SUM_W-1:0]        x_mag;
  logic [H_W-1:0]          h_q;
  logic [S1_W-1:0]         s1_q;
  logic                    neg4_q, neg5_q;
  logic [H2_W-1:0]         h2;
  logic [QA_W-1:0]         qa_q;
  logic [S2_W-1:0]         s2_q;
  logic [H3_W-1:0]         h3;
  logic [S3_W-1:0]         s3;
  logic [QA_W-1:0]         qsum;
  logic [VAL_W-1:0]        qmag;
  logic [VAL_W-1:0]        val;
  logic                    out_valid_q;
  out_item_t               out_q;

  // ---------------- configuration ----------------
  assign cfg_ready_o = !zc_busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_wr && (cfg_index_i inside {CFG_MIN_VALUE, CFG_MAX_VALUE});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_RESET;
      max_q <= MAX_RESET;
      den_q <= DEN_W'(MAX_RESET) - DEN_W'(MIN_RESET);
    end else begin
      if (cfg_wr) begin
        case (cfg_index_i)
          CFG_MIN_VALUE: min_q <= cfg_data_i;
          CFG_MAX_VALUE: max_q <= cfg_data_i;
          default: ;
        endcase
      end
      den_q <= DEN_W'(max_q) - DEN_W'(min_q);
    end
  end

  bsde_zc_div u_zc_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cfg_hit),
    .min_i  (min_q),
    .max_i  (max_q),
    .busy_o (zc_busy),
    .zc_o   (zc)
  );

  // ---------------- code buffer ----------------
  assign full    = held_q == CNT_W'(DEPTH);
  assign push_ok = cmd_i.push && !full;
  assign bit_set = flag_q[cmd_i.pos];
  assign pop     = cmd_i.issue && bit_set && (held_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      held_q       <= '0;
      ovf_sticky_q <= 1'b0;
      ovf_word_q   <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
        held_q   <= held_q + CNT_W'(1);
      end else if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
        held_q   <= held_q - CNT_W'(1);
      end
      if (cmd_i.push && full) begin
        ovf_sticky_q <= 1'b1;
      end else if (cmd_i.load_word) begin
        // Report the dropped codes on every item of this word, then rearm
        ovf_word_q   <= ovf_sticky_q;
        ovf_sticky_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      code_mem_q[wr_ptr_q] <= code_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_code_q <= code_mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word) begin
      flag_q <= flag_word_i;
    end
  end

  // ---------------- element pipeline ----------------
  // The whole pipe advances together and freezes while the output item waits
  assign adv = !out_valid_q || !out_stall_i;

  always_comb begin
    m1_d          = '0;
    m1_d.valid    = cmd_i.issue;
    m1_d.use_code = pop;
    m1_d.pos      = cmd_i.pos;
    m1_d.last     = cmd_i.last;
    m1_d.under    = bit_set && (held_q == '0);
    m1_d.ovf      = ovf_word_q;
  end

  assign code_ext = $signed({2'b00, rd_code_q});

  always_comb begin
    m2_d      = m1_q;
    // Clear bits, empty buffer and the two codes around zero all give zero
    m2_d.zero = !m1_q.use_code || (code_ext == zc) || (code_ext == zc + ZC_W'(1));
  end

  assign min_scaled = SUM_W'($signed({min_q, {CODE_BITS{1'b0}}})) - SUM_W'(min_q);
  assign x_mag      = x_q[SUM_W-1] ? SUM_W'(-x_q) : SUM_W'(x_q);

  // Divide by 2^m - 1 through folding: a = h*2^m + l = h*(2^m - 1) + (h + l)
  assign h2   = s1_q[S1_W-1:CODE_BITS];
  assign h3   = s2_q[S2_W-1:CODE_BITS];
  assign s3   = S3_W'(h3) + S3_W'(s2_q[CODE_BITS-1:0]);
  assign qsum = qa_q + QA_W'(h3) + QA_W'(s3 >= CODE_SPAN);
  assign qmag = qsum[VAL_W-1:0];
  assign val  = neg5_q ? -qmag : qmag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q        <= '0;
      m2_q        <= '0;
      m3_q        <= '0;
      m4_q        <= '0;
      m5_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      m1_q        <= m1_d;
      m2_q        <= m2_d;
      m3_q        <= m2_q;
      m4_q        <= m3_q;
      m5_q        <= m4_q;
      out_valid_q <= m5_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= $signed({1'b0, rd_code_q}) * den_q;
      x_q    <= SUM_W'(prod_q) + min_scaled;
      neg4_q <= x_q[SUM_W-1];
      h_q    <= x_mag[MAG_W-1:CODE_BITS];
      s1_q   <= S1_W'(x_mag[MAG_W-1:CODE_BITS]) + S1_W'(x_mag[CODE_BITS-1:0]);
      neg5_q <= neg4_q;
      qa_q   <= QA_W'(h_q) + QA_W'(h2);
      s2_q   <= S2_W'(h2) + S2_W'(s1_q[CODE_BITS-1:0]);
      out_q.out_value     <= m5_q.zero ? '0 : $signed(val);
      out_q.position      <= m5_q.pos;
      out_q.last_of_word  <= m5_q.last;
      out_q.underflow     <= m5_q.under;
      out_q.overflow_seen <= m5_q.ovf;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_q;
  assign status_o.zc_busy = zc_busy;
  assign status_o.adv     = adv;

  `BSDE_ASSERT(a_held_matches_ptrs, held_q[PTR_W-1:0] == PTR_W'(wr_ptr_q - rd_ptr_q), "code count disagrees with buffer pointers")
  `BSDE_ASSERT(a_full_push_flags, (cmd_i.push && full) |=> ovf_sticky_q, "dropped code not flagged")
  `BSDE_ASSERT_NEVER(a_underflow_nonzero, out_valid_o && out_item_o.underflow && (out_item_o.out_value != '0), "underflow item carries a nonzero value")

endmodule

@@ rtl/core/bsde_ctrl.sv @@
// Controller: accepts items and steps through the positions of a flag word
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsde_ctrl import bsde_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  req_type_e         req_type_i,
  input  logic [NPOS_W-1:0] valid_positions_i,
  output logic              in_stall_o,
  input  dp_status_t        status_i,
  output dp_cmd_t           cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } ctrl_state_e;

  ctrl_state_e       state_q, state_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [NPOS_W-1:0] n_q, n_d;
  logic [NPOS_W-1:0] n_sat;
  logic              accept;
  logic              last;

  assign n_sat = (valid_positions_i > NPOS_W'(WORD_LIMIT)) ? NPOS_W'(WORD_LIMIT)
                                                          : valid_positions_i;
  assign in_stall_o = (state_q != ST_IDLE) || status_i.zc_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign last       = ({1'b0, pos_q} + NPOS_W'(1)) == n_q;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    n_d       = n_q;
    cmd_o     = '0;
    cmd_o.pos = pos_q;
    cmd_o.last = last;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_CODE: cmd_o.push = 1'b1;
            REQ_FLAGS: begin
              // A word with no positions emits nothing and keeps the sticky flag
              if (n_sat != '0) begin
                cmd_o.load_word = 1'b1;
                n_d             = n_sat;
                pos_d           = '0;
                state_d         = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (status_i.adv) begin
          cmd_o.issue = 1'b1;
          pos_d       = pos_q + POS_W'(1);
          if (last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      n_q     <= n_d;
    end
  end

  `BSDE_ASSERT(a_pos_in_word, (state_q == ST_RUN) |-> ({1'b0, pos_q} < n_q), "position beyond word length")
  `BSDE_ASSERT(a_load_enters_run, cmd_o.load_word |=> (state_q == ST_RUN), "flag word loaded without stepping")

endmodule

@@ rtl/core/bitmask_sparse_dequant_expand_top.sv @@
// Top level of the sparse bitmask expander with uniform dequantization
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i): req_type REQ_CODE
//   pushes one code into a 64-entry buffer; REQ_FLAGS supplies a flag word
//   and yields one output item per valid position, lowest first.
//   Set bits take the next buffered code, clear bits give zero.
//   Output channel (out_valid_o / out_stall_i / out_item_o): registered.
//   The first item of a word passes the issue step, the element pipeline
//   registers and the output register; later items follow one per cycle
//   while the output is not stalled. A word of n positions stalls the input
//   until its last position is issued, one issue per position.
//   Config channel (cfg_valid_i / cfg_ready_o): a write to min or max starts
//   the zero-code divider, one quotient bit per cycle; cfg_ready_o and the
//   input channel are held off until it finishes.
//   Reset: buffer empty, min 0.0, max 1.0, zero code 0; no clearing pass.
//   Output stall freezes the whole element pipeline; nothing is dropped.
module bitmask_sparse_dequant_expand_top import bsde_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VAL_W-1:0]     cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bsde_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .req_type_i       (in_item_i.req_type),
    .valid_positions_i(in_item_i.valid_positions),
    .in_stall_o       (in_stall_o),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  bsde_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .code_i     (in_item_i.code),
    .flag_word_i(in_item_i.flag_word),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
